/* rtl/svec_pkg.sv */
`default_nettype none

package svec_pkg;

   // fixed field widths
   localparam int RADIUS_BITS   = 37;
   localparam int MODE_BITS     = 2;
   localparam int KIND_BITS     = 2;
   localparam int CSR_ADDR_BITS = 3;

   // defaults for the top level parameters
   localparam int DEF_COORD_BITS = 17;
   localparam int DEF_COLOR_BITS = 32;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CENTER_Z    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RADIUS_SQ   = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EDIT_MODE   = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BRUSH_COLOR = 3'd5;

   // edit modes, code 3 acts as fill
   localparam logic [MODE_BITS-1:0] MODE_FILL  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DIG   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_PAINT = 2'd2;

   // node classification
   localparam logic [KIND_BITS-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_PROCEED = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_FILL    = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR   = 2'd3;

   // item selector
   localparam logic ACTION_NODE  = 1'b0;
   localparam logic ACTION_VOXEL = 1'b1;

   // per-transaction flags carried down the pipeline
   typedef struct packed {
      logic action;
      logic has_node;
      logic present;
      logic cur_empty;
      logic with_color;
   } flags_type;

endpackage

`default_nettype wire

/* rtl/sphere_voxel_edit_classifier.sv */
`default_nettype none

// channel    dir   ports                        content
// req        in    req_tvalid/tready/tdata/     node box or voxel query
//                  tuser
// rsp        out   rsp_tvalid/tready/tdata      edit kind, occupancy, color
// csr        in    csr_we/csr_addr/csr_wdata    sphere center, radius, mode, brush
//
// one transaction per cycle sustained while rsp is ready; four register stages
// (input, squares, sums, result), and rsp_tvalid comes from the result stage
// the squaring stage holds six squarers of COORD_BITS+1 bits
// reset is synchronous and active high: it empties the pipeline and zeroes
// the configuration registers
// a stall on rsp backs up stage by stage; empty stages still take new work,
// so req_tready stays high until every stage holds a transaction
// configuration is read live by the stages and must only change when idle
module sphere_voxel_edit_classifier #(
   parameter int COORD_BITS = svec_pkg::DEF_COORD_BITS,
   parameter int COLOR_BITS = svec_pkg::DEF_COLOR_BITS
) (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic req_tvalid,
   output logic      req_tready,
   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, has_node, voxel_present,
   // current_color, current_empty, with_color, zero fill
   input  wire logic [((6*(COORD_BITS+1)+COLOR_BITS+4+7)/8)*8-1:0] req_tdata,
   // action
   input  wire logic req_tuser,

   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // edit_kind, voxel_out, color_out, color_empty, zero fill
   output logic      [((COLOR_BITS+4+7)/8)*8-1:0] rsp_tdata,

   input  wire logic                                csr_we,
   input  wire logic [svec_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [((COLOR_BITS > svec_pkg::RADIUS_BITS) ?
                       COLOR_BITS : svec_pkg::RADIUS_BITS)-1:0] csr_wdata
);
   import svec_pkg::*;

   localparam int POS_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * POS_BITS;
   localparam int SUM_BITS  = 2 * COORD_BITS + 5;
   // request field offsets inside tdata
   localparam int OFF_HAS   = 6 * POS_BITS;
   localparam int OFF_PRES  = OFF_HAS + 1;
   localparam int OFF_COLOR = OFF_HAS + 2;
   localparam int OFF_EMPTY = OFF_COLOR + COLOR_BITS;
   localparam int OFF_WITH  = OFF_EMPTY + 1;
   // response field offsets inside tdata
   localparam int OFF_VOUT  = KIND_BITS;
   localparam int OFF_COUT  = KIND_BITS + 1;
   localparam int OFF_CEMP  = OFF_COUT + COLOR_BITS;

   // configuration registers
   logic [COORD_BITS-1:0]  center_ff [3];
   logic [RADIUS_BITS-1:0] radius_sq_ff;
   logic [MODE_BITS-1:0]   edit_mode_ff;
   logic [COLOR_BITS-1:0]  brush_color_ff;

   // stage handshakes: a stage may load when it is empty or moving on
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic adv0, adv1, adv2, adv3;
   logic v0_in, v1_in, v2_in, v3_in;

   // stage 0: captured request
   logic [POS_BITS-1:0]   s0_lo_in   [3];
   logic [POS_BITS-1:0]   s0_hi_in   [3];
   logic [POS_BITS-1:0]   s0_lo_ff   [3];
   logic [POS_BITS-1:0]   s0_hi_ff   [3];
   flags_type             s0_flags_in, s0_flags_ff;
   logic [COLOR_BITS-1:0] s0_color_ff;

   // stage 1: squared distances
   logic [SQ_BITS-1:0]    s1_lo_sq_in [3];
   logic [SQ_BITS-1:0]    s1_hi_sq_in [3];
   logic [SQ_BITS-1:0]    s1_lo_sq_ff [3];
   logic [SQ_BITS-1:0]    s1_hi_sq_ff [3];
   logic [2:0]            s1_above_in, s1_above_ff;
   logic [2:0]            s1_below_in, s1_below_ff;
   flags_type             s1_flags_ff;
   logic [COLOR_BITS-1:0] s1_color_ff;

   // stage 2: farthest corner, nearest point and voxel point sums
   logic [SUM_BITS-1:0]   s2_far_in, s2_near_in, s2_pt_in;
   logic [SUM_BITS-1:0]   s2_far_ff, s2_near_ff, s2_pt_ff;
   flags_type             s2_flags_ff;
   logic [COLOR_BITS-1:0] s2_color_ff;

   // stage 3: result register
   logic [KIND_BITS-1:0]  kind_in, kind_ff;
   logic                  vout_in, vout_ff;
   logic [COLOR_BITS-1:0] cout_in, cout_ff;
   logic                  cempty_in, cempty_ff;
   logic                  act_ff;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0]   <= '0;
         center_ff[1]   <= '0;
         center_ff[2]   <= '0;
         radius_sq_ff   <= '0;
         edit_mode_ff   <= MODE_FILL;
         brush_color_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CENTER_X:    center_ff[0]   <= csr_wdata[COORD_BITS-1:0];
            CSR_CENTER_Y:    center_ff[1]   <= csr_wdata[COORD_BITS-1:0];
            CSR_CENTER_Z:    center_ff[2]   <= csr_wdata[COORD_BITS-1:0];
            CSR_RADIUS_SQ:   radius_sq_ff   <= csr_wdata[RADIUS_BITS-1:0];
            CSR_EDIT_MODE:   edit_mode_ff   <= csr_wdata[MODE_BITS-1:0];
            CSR_BRUSH_COLOR: brush_color_ff <= csr_wdata[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // backpressure chain from the result register up to the input
   assign adv3       = !v3_ff || rsp_tready;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign adv0       = !v0_ff || adv1;
   assign req_tready = adv0;

   assign v0_in = adv0 ? req_tvalid : v0_ff;
   assign v1_in = adv1 ? v0_ff      : v1_ff;
   assign v2_in = adv2 ? v1_ff      : v2_ff;
   assign v3_in = adv3 ? v2_ff      : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // request unpacking
   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign s0_lo_in[i] = req_tdata[i*POS_BITS +: POS_BITS];
      assign s0_hi_in[i] = req_tdata[(i+3)*POS_BITS +: POS_BITS];
   end

   assign s0_flags_in.action     = req_tuser;
   assign s0_flags_in.has_node   = req_tdata[OFF_HAS];
   assign s0_flags_in.present    = req_tdata[OFF_PRES];
   assign s0_flags_in.cur_empty  = req_tdata[OFF_EMPTY];
   assign s0_flags_in.with_color = req_tdata[OFF_WITH];

   always_ff @(posedge clock) begin
      if (req_tvalid && adv0) begin
         for (int i = 0; i < 3; i++) begin
            s0_lo_ff[i] <= s0_lo_in[i];
            s0_hi_ff[i] <= s0_hi_in[i];
         end
         s0_flags_ff <= s0_flags_in;
         s0_color_ff <= req_tdata[OFF_COLOR +: COLOR_BITS];
      end
   end

   // one squaring unit per axis
   for (genvar i = 0; i < 3; i++) begin : g_axis
      svec_axis_sq #(
         .COORD_BITS (COORD_BITS)
      ) u_axis (
         .lo       (s0_lo_ff[i]),
         .hi       (s0_hi_ff[i]),
         .center   (center_ff[i]),
         .lo_sq    (s1_lo_sq_in[i]),
         .hi_sq    (s1_hi_sq_in[i]),
         .lo_above (s1_above_in[i]),
         .hi_below (s1_below_in[i])
      );
   end

   always_ff @(posedge clock) begin
      if (v0_ff && adv1) begin
         for (int i = 0; i < 3; i++) begin
            s1_lo_sq_ff[i] <= s1_lo_sq_in[i];
            s1_hi_sq_ff[i] <= s1_hi_sq_in[i];
         end
         s1_above_ff <= s1_above_in;
         s1_below_ff <= s1_below_in;
         s1_flags_ff <= s0_flags_ff;
         s1_color_ff <= s0_color_ff;
      end
   end

   // far term is the larger corner per axis; near term counts a bound only
   // when the center lies outside the box on that side
   always_comb begin
      logic [SQ_BITS-1:0] far_term;
      s2_far_in  = '0;
      s2_near_in = '0;
      s2_pt_in   = '0;
      for (int i = 0; i < 3; i++) begin
         far_term   = (s1_lo_sq_ff[i] > s1_hi_sq_ff[i]) ? s1_lo_sq_ff[i] : s1_hi_sq_ff[i];
         s2_far_in  = s2_far_in + SUM_BITS'(far_term);
         s2_pt_in   = s2_pt_in + SUM_BITS'(s1_lo_sq_ff[i]);
         if (s1_above_ff[i]) begin
            s2_near_in = s2_near_in + SUM_BITS'(s1_lo_sq_ff[i]);
         end
         if (s1_below_ff[i]) begin
            s2_near_in = s2_near_in + SUM_BITS'(s1_hi_sq_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff && adv2) begin
         s2_far_ff   <= s2_far_in;
         s2_near_ff  <= s2_near_in;
         s2_pt_ff    <= s2_pt_in;
         s2_flags_ff <= s1_flags_ff;
         s2_color_ff <= s1_color_ff;
      end
   end

   svec_decide #(
      .COORD_BITS (COORD_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_decide (
      .far_sum     (s2_far_ff),
      .near_sum    (s2_near_ff),
      .pt_sum      (s2_pt_ff),
      .radius_sq   (radius_sq_ff),
      .edit_mode   (edit_mode_ff),
      .brush_color (brush_color_ff),
      .flags       (s2_flags_ff),
      .cur_color   (s2_color_ff),
      .edit_kind   (kind_in),
      .voxel_out   (vout_in),
      .color_out   (cout_in),
      .color_empty (cempty_in)
   );

   always_ff @(posedge clock) begin
      if (v2_ff && adv3) begin
         kind_ff   <= kind_in;
         vout_ff   <= vout_in;
         cout_ff   <= cout_in;
         cempty_ff <= cempty_in;
         act_ff    <= s2_flags_ff.action;
      end
   end

   // response packing
   assign rsp_tvalid = v3_ff;

   always_comb begin
      rsp_tdata                         = '0;
      rsp_tdata[KIND_BITS-1:0]          = kind_ff;
      rsp_tdata[OFF_VOUT]               = vout_ff;
      rsp_tdata[OFF_COUT +: COLOR_BITS] = cout_ff;
      rsp_tdata[OFF_CEMP]               = cempty_ff;
   end

   // voxel transactions never classify a node
   assert property (@(posedge clock) disable iff (reset)
      v3_ff && act_ff == ACTION_VOXEL |-> kind_ff == KIND_NONE)
      else $error("voxel result carries a node kind");

   // node transactions never report occupancy
   assert property (@(posedge clock) disable iff (reset)
      v3_ff && act_ff == ACTION_NODE |-> !vout_ff)
      else $error("node result carries voxel occupancy");

   // an emptied node color is the zero word
   assert property (@(posedge clock) disable iff (reset)
      v3_ff && act_ff == ACTION_NODE && cempty_ff |-> cout_ff == '0)
      else $error("empty node color is not zero");

   // clear only comes from dig mode, fill never does
   assert property (@(posedge clock) disable iff (reset)
      v3_ff && kind_ff == KIND_CLEAR |-> edit_mode_ff == MODE_DIG)
      else $error("clear outside dig mode");

   assert property (@(posedge clock) disable iff (reset)
      v3_ff && kind_ff == KIND_FILL |-> edit_mode_ff != MODE_DIG)
      else $error("fill in dig mode");

endmodule

`default_nettype wire

/* rtl/svec_axis_sq.sv */
`default_nettype none

// squared distances of both box bounds to the center along one axis
module svec_axis_sq #(
   parameter int COORD_BITS = svec_pkg::DEF_COORD_BITS
) (
   input  wire logic [COORD_BITS:0]       lo,
   input  wire logic [COORD_BITS:0]       hi,
   input  wire logic [COORD_BITS-1:0]     center,
   output logic      [2*COORD_BITS+1:0]   lo_sq,
   output logic      [2*COORD_BITS+1:0]   hi_sq,
   output logic                           lo_above,
   output logic                           hi_below
);
   localparam int POS_BITS = COORD_BITS + 1;
   localparam int SQ_BITS  = 2 * POS_BITS;

   logic [POS_BITS-1:0] c_ext;
   logic [POS_BITS-1:0] lo_d;
   logic [POS_BITS-1:0] hi_d;

   assign c_ext    = {1'b0, center};
   assign lo_above = lo > c_ext;
   assign hi_below = hi < c_ext;
   assign lo_d     = (lo >= c_ext) ? (lo - c_ext) : (c_ext - lo);
   assign hi_d     = (hi >= c_ext) ? (hi - c_ext) : (c_ext - hi);
   assign lo_sq    = SQ_BITS'(lo_d) * SQ_BITS'(lo_d);
   assign hi_sq    = SQ_BITS'(hi_d) * SQ_BITS'(hi_d);

endmodule

`default_nettype wire

/* rtl/svec_decide.sv */
`default_nettype none

// radius compares and the per-mode edit decision
module svec_decide #(
   parameter int COORD_BITS = svec_pkg::DEF_COORD_BITS,
   parameter int COLOR_BITS = svec_pkg::DEF_COLOR_BITS
) (
   input  wire logic [2*COORD_BITS+4:0]             far_sum,
   input  wire logic [2*COORD_BITS+4:0]             near_sum,
   input  wire logic [2*COORD_BITS+4:0]             pt_sum,
   input  wire logic [svec_pkg::RADIUS_BITS-1:0]    radius_sq,
   input  wire logic [svec_pkg::MODE_BITS-1:0]      edit_mode,
   input  wire logic [COLOR_BITS-1:0]               brush_color,
   input  wire svec_pkg::flags_type                 flags,
   input  wire logic [COLOR_BITS-1:0]               cur_color,
   output logic      [svec_pkg::KIND_BITS-1:0]      edit_kind,
   output logic                                     voxel_out,
   output logic      [COLOR_BITS-1:0]               color_out,
   output logic                                     color_empty
);
   import svec_pkg::*;

   localparam int SUM_BITS = 2 * COORD_BITS + 5;
   localparam int CMP_BITS = (SUM_BITS > RADIUS_BITS) ? SUM_BITS : RADIUS_BITS;

   logic                 dig;
   logic                 paint;
   logic                 colored;
   logic                 far_in;
   logic                 near_out;
   logic                 pt_in;
   logic [KIND_BITS-1:0] base_kind;

   assign dig      = edit_mode == MODE_DIG;
   assign paint    = edit_mode == MODE_PAINT;
   assign colored  = flags.with_color && !dig;
   assign far_in   = CMP_BITS'(far_sum) <= CMP_BITS'(radius_sq);
   assign near_out = CMP_BITS'(near_sum) > CMP_BITS'(radius_sq);
   assign pt_in    = CMP_BITS'(pt_sum) <= CMP_BITS'(radius_sq);

   always_comb begin
      priority if (far_in) begin
         base_kind = dig ? KIND_CLEAR : KIND_FILL;
      end else if (near_out) begin
         base_kind = KIND_NONE;
      end else begin
         base_kind = KIND_PROCEED;
      end
   end

   always_comb begin
      edit_kind   = KIND_NONE;
      voxel_out   = 1'b0;
      color_out   = '0;
      color_empty = 1'b0;
      if (flags.action == ACTION_NODE) begin
         edit_kind = base_kind;
         if (colored) begin
            priority if (base_kind == KIND_FILL) begin
               color_out = brush_color;
               if (paint) begin
                  edit_kind = KIND_NONE;
               end
            end else if (!flags.has_node ||
                         (!flags.cur_empty && cur_color == brush_color)) begin
               color_out = brush_color;
            end else begin
               color_empty = 1'b1;
            end
            if (paint && !flags.has_node) begin
               edit_kind = KIND_NONE;
            end
         end
      end else begin
         if (colored) begin
            if (pt_in || !flags.present) begin
               color_out = brush_color;
            end else begin
               color_out   = cur_color;
               color_empty = flags.cur_empty;
            end
            voxel_out = paint ? flags.present : (flags.present || pt_in);
         end else if (paint) begin
            voxel_out = flags.present;
         end else if (dig) begin
            voxel_out = flags.present && !pt_in;
         end else begin
            voxel_out = flags.present || pt_in;
         end
      end
   end

endmodule

`default_nettype wire
